/* rtl/predictive_echo_tracker_core_assert.svh */
// Assertion macros shared by the tracker RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef PREDICTIVE_ECHO_TRACKER_CORE_ASSERT_SVH
`define PREDICTIVE_ECHO_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define PET_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PET_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PET_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/pet_pkg.sv */
// Package for the predictive echo tracker: payload structs, codes, constants.
// Used by pet_dp, pet_ctrl and predictive_echo_tracker_core.
package pet_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [7:0]  PRINT_LO   = 8'h20;
  localparam logic [7:0]  PRINT_HI   = 8'h7f;
  localparam logic [20:0] CELL_BLANK = 21'h20;
  localparam logic [20:0] CELL_EMPTY = 21'h0;

  // Item kinds.
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_BEGIN   = 3'd1;
  localparam logic [2:0] KIND_CELL    = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_OVERLAY = 3'd4;
  localparam logic [2:0] KIND_RESET   = 3'd5;

  // Configuration register indexes.
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam logic [15:0] GRID_ROWS_RESET = 16'd24;
  localparam logic [15:0] GRID_COLS_RESET = 16'd80;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] srv_row;
    logic [15:0] srv_col;
    logic [20:0] cell_char;
    logic        cell_present;
  } item_t;

  typedef struct packed {
    logic             changed;
    logic             entry_valid;
    logic [15:0]      entry_row;
    logic [15:0]      entry_col;
    logic [6:0]       entry_char;
    logic             on_grid;
    logic             cursor_move;
    logic [15:0]      cursor_row_new;
    logic [15:0]      cursor_col_new;
    logic             mismatch;
    logic [6:0]       pending_count;
    logic             last_result;
  } result_t;

  // One stored prediction.
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [6:0]  ch;
  } slot_t;

  // Memory read address source.
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_KEEP,
    RD_PTR
  } rd_sel_t;

  // Result format written into the output register.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PLAIN,
    EMIT_QUERY,
    EMIT_OVERLAY
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      key;
    logic      frame_begin;
    logic      frame_cell;
    logic      close;
    logic      clear;
    logic      ov_init;
    emit_sel_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic ov_empty;
    logic ov_last;
  } dp_status_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

/* rtl/pet_dp.sv */
// Datapath of the predictive echo tracker: prediction memory, tracking state,
// configuration registers and the output register. Depends on pet_pkg.
module pet_dp import pet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  slot_t mem [DEPTH];
  slot_t rd_q;
  item_t in_q;

  logic [CNT_W-1:0] entry_count;
  logic [15:0]      next_row;
  logic [15:0]      next_col;
  logic             anchored;
  logic             frame_open;
  logic             frame_aborted;
  logic [CNT_W-1:0] scan_index;
  logic [CNT_W-1:0] keep_index;
  logic             chg_flag;
  logic             mis_flag;
  logic [CNT_W-1:0] ov_rem;
  logic [CNT_W-1:0] ov_ptr;
  logic [15:0]      grid_rows;
  logic [15:0]      grid_cols;

  logic             out_free;
  logic             frame_live;
  logic             scan_active;
  logic             printable;
  logic             cell_hit;
  logic             cell_clash;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] keep_last;
  logic [CNT_W-1:0] ov_ptr_next;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  result_t          res;

  assign out_free    = !result_valid || !result_stall;
  assign frame_live  = frame_open && !frame_aborted;
  assign scan_active = frame_live && (scan_index < entry_count);
  assign printable   = (in_q.byte_value >= PRINT_LO) && (in_q.byte_value < PRINT_HI);
  assign cell_hit    = !in_q.cell_present || (in_q.cell_char == {14'd0, rd_q.ch});
  assign cell_clash  = (in_q.cell_char != CELL_EMPTY) && (in_q.cell_char != CELL_BLANK);
  assign keep_last   = IDX_W'(keep_index - CNT_W'(1));

  assign status.out_free = out_free;
  assign status.ov_empty = (ov_rem == '0);
  assign status.ov_last  = (ov_rem == CNT_W'(1));

  // Overlay walk: kept entries first, then the unreported tail of the frame.
  always_comb begin
    ov_ptr_next = ov_ptr + CNT_W'(1);
    if (frame_live && (ov_ptr_next == keep_index)) begin
      ov_ptr_next = scan_index;
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN: rd_addr = scan_index[IDX_W-1:0];
      RD_KEEP: rd_addr = keep_last;
      RD_PTR:  rd_addr = ov_ptr[IDX_W-1:0];
      default: rd_addr = scan_index[IDX_W-1:0];
    endcase
  end

  // Memory write: keystroke append or compaction of a kept entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_count[IDX_W-1:0];
    mem_wdata = '{row: next_row, col: next_col, ch: in_q.byte_value[6:0]};
    if (cmd.key && anchored && !frame_open && printable &&
        (entry_count != CNT_W'(DEPTH))) begin
      mem_we = 1'b1;
    end else if (cmd.frame_cell && scan_active && !cell_hit && !cell_clash) begin
      mem_we    = 1'b1;
      mem_waddr = keep_index[IDX_W-1:0];
      mem_wdata = rd_q;
    end
  end

  // Prediction memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Input item latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= item;
    end
  end

  // Tracking state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      next_row      <= '0;
      next_col      <= '0;
      anchored      <= 1'b0;
      frame_open    <= 1'b0;
      frame_aborted <= 1'b0;
      scan_index    <= '0;
      keep_index    <= '0;
      chg_flag      <= 1'b0;
      mis_flag      <= 1'b0;
      ov_rem        <= '0;
      ov_ptr        <= '0;
      grid_rows     <= GRID_ROWS_RESET;
      grid_cols     <= GRID_COLS_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_ROWS) begin
          grid_rows <= cfg_data;
        end else begin
          grid_cols <= cfg_data;
        end
      end
      if (cmd.load) begin
        chg_flag <= 1'b0;
        mis_flag <= 1'b0;
      end
      // Keystroke: append a printable byte or drop the whole list.
      if (cmd.key && anchored && !frame_open) begin
        chg_flag <= 1'b1;
        if (!printable || (entry_count == CNT_W'(DEPTH))) begin
          entry_count <= '0;
          anchored    <= 1'b0;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
          next_col    <= sat_inc(next_col);
        end
      end
      // Frame begin: close any open frame, anchor at the server cursor.
      if (cmd.frame_begin) begin
        if (frame_live) begin
          entry_count <= keep_index;
        end
        next_row      <= in_q.srv_row;
        next_col      <= in_q.srv_col;
        anchored      <= 1'b1;
        frame_open    <= 1'b1;
        frame_aborted <= 1'b0;
        scan_index    <= '0;
        keep_index    <= '0;
      end
      // Frame cell: compare against the pending entry under the scan.
      if (cmd.frame_cell && scan_active) begin
        if (cell_hit) begin
          scan_index <= scan_index + CNT_W'(1);
        end else if (cell_clash) begin
          entry_count   <= '0;
          frame_aborted <= 1'b1;
          mis_flag      <= 1'b1;
        end else begin
          keep_index <= keep_index + CNT_W'(1);
          scan_index <= scan_index + CNT_W'(1);
        end
      end
      // Frame end: compact and continue after the last kept entry.
      if (cmd.close && frame_open) begin
        if (!frame_aborted) begin
          entry_count <= keep_index;
          if (keep_index != '0) begin
            next_row <= rd_q.row;
            next_col <= sat_inc(rd_q.col);
          end
        end
        frame_open    <= 1'b0;
        frame_aborted <= 1'b0;
      end
      // Reset item.
      if (cmd.clear) begin
        entry_count   <= '0;
        anchored      <= 1'b0;
        frame_open    <= 1'b0;
        frame_aborted <= 1'b0;
        scan_index    <= '0;
        keep_index    <= '0;
      end
      // Overlay setup and walk.
      if (cmd.ov_init) begin
        if (frame_live) begin
          ov_rem <= keep_index + (entry_count - scan_index);
          ov_ptr <= (keep_index == '0) ? scan_index : '0;
        end else begin
          ov_rem <= entry_count;
          ov_ptr <= '0;
        end
      end
      if (cmd.emit == EMIT_OVERLAY) begin
        ov_rem <= ov_rem - CNT_W'(1);
        ov_ptr <= ov_ptr_next;
      end
    end
  end

  // Result formatting.
  always_comb begin
    res               = '0;
    res.pending_count = 7'(entry_count);
    res.last_result   = 1'b1;
    case (cmd.emit)
      EMIT_PLAIN: begin
        res.changed = chg_flag;
      end
      EMIT_QUERY: begin
        res.mismatch = mis_flag;
        if (scan_active) begin
          res.entry_valid = 1'b1;
          res.entry_row   = rd_q.row;
          res.entry_col   = rd_q.col;
          res.entry_char  = rd_q.ch;
        end
      end
      EMIT_OVERLAY: begin
        res.entry_valid = 1'b1;
        res.entry_row   = rd_q.row;
        res.entry_col   = rd_q.col;
        res.entry_char  = rd_q.ch;
        res.on_grid     = (rd_q.row < grid_rows) && (rd_q.col < grid_cols);
        res.last_result = status.ov_last;
        if (status.ov_last && (({1'b0, rd_q.col} + 17'd1) < {1'b0, grid_cols})) begin
          res.cursor_move    = 1'b1;
          res.cursor_row_new = rd_q.row;
          res.cursor_col_new = sat_inc(rd_q.col);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Output register: holds one transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      result <= res;
    end
  end

endmodule

/* rtl/pet_ctrl.sv */
// Controller of the predictive echo tracker: sequences each item through the
// datapath with command and status structs. Depends on pet_pkg.
module pet_ctrl import pet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [2:0] item_kind,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       item_stall
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY,
    S_BEG,
    S_CELL_RD,
    S_CELL_EX,
    S_SHOW_RD,
    S_SHOW,
    S_END_RD,
    S_END_EX,
    S_RST,
    S_EMIT,
    S_OV_INIT,
    S_OV_RD,
    S_OV_EM
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SCAN;
    cmd.emit   = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          case (item_kind)
            KIND_KEY:     state_next = S_KEY;
            KIND_BEGIN:   state_next = S_BEG;
            KIND_CELL:    state_next = S_CELL_RD;
            KIND_END:     state_next = S_END_RD;
            KIND_OVERLAY: state_next = S_OV_INIT;
            KIND_RESET:   state_next = S_RST;
            default:      state_next = S_EMIT;
          endcase
        end
      end
      S_KEY: begin
        cmd.key    = 1'b1;
        state_next = S_EMIT;
      end
      S_BEG: begin
        cmd.frame_begin = 1'b1;
        state_next      = S_SHOW_RD;
      end
      S_CELL_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CELL_EX;
      end
      S_CELL_EX: begin
        cmd.frame_cell = 1'b1;
        state_next     = S_SHOW_RD;
      end
      S_SHOW_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_QUERY;
          state_next = S_IDLE;
        end
      end
      S_END_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_KEEP;
        state_next = S_END_EX;
      end
      S_END_EX: begin
        cmd.close  = 1'b1;
        state_next = S_EMIT;
      end
      S_RST: begin
        cmd.clear  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_PLAIN;
          state_next = S_IDLE;
        end
      end
      S_OV_INIT: begin
        cmd.ov_init = 1'b1;
        state_next  = S_OV_RD;
      end
      S_OV_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_next = status.ov_empty ? S_EMIT : S_OV_EM;
      end
      S_OV_EM: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_OVERLAY;
          state_next = status.ov_last ? S_IDLE : S_OV_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/predictive_echo_tracker_core.sv */
// Predictive echo tracker, top level.
// Item channel: item_valid / item_stall carry one item_t per transaction; the
//   kind field selects keystroke, frame begin, frame cell, frame end, overlay
//   or reset.
// Result channel: result_valid / result_stall carry one result_t per
//   transaction; last_result marks the final result of an item.
// Configuration: cfg_we writes cfg_data into grid_rows (index 0) or
//   grid_cols (index 1); write only while the block is idle.
// Timing: one item is worked at a time. Keystroke and reset update the state
//   before their plain result, frame end reads the last kept entry and closes
//   first, other plain kinds send it directly. Frame begin and frame cell end
//   in a memory read and a query result. An overlay sends each entry after one
//   registered read of the prediction memory, or a plain result if empty.
// The next item is accepted as soon as the last result sits in the output
//   register, even if the receiver has not taken it yet. A stalled receiver
//   holds the result and the sequencer waits before writing another.
// Reset clears the list, unanchors the tracker, loads grid 24 x 80 and empties
//   the output register; the memory needs no clearing pass.
`include "predictive_echo_tracker_core_assert.svh"

module predictive_echo_tracker_core import pet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       hint_ok;
  logic       entry_blank;

  // Sequencer.
  pet_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // Storage and result formatting.
  pet_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Helper terms for the checks below.
  assign hint_ok     = result.last_result && result.entry_valid;
  assign entry_blank = (result.entry_row == 16'd0) && (result.entry_col == 16'd0) &&
                       (result.entry_char == 7'd0);

  // An accepted item always keeps the sequencer busy in the next cycle.
  `PET_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && !item_stall, item_stall)
  // The pending count never exceeds the memory depth.
  `PET_ASSERT_IMPL(a_count_bound, clk, rst, result_valid, result.pending_count <= 7'(DEPTH))
  // A cursor hint only comes with the final overlay result.
  `PET_ASSERT_IMPL(a_hint_last, clk, rst, result_valid && result.cursor_move, hint_ok)
  // Entry fields are zero when no entry is shown.
  `PET_ASSERT_IMPL(a_entry_zero, clk, rst, result_valid && !result.entry_valid, entry_blank)

endmodule
